// ===== sv/npwp_pkg.sv =====
// shared types, constants and helpers of the nibble pixel word packer
// used by every design module of the block; depends on nothing
`default_nettype none

package npwp_pkg;

  localparam int unsigned MAX_DIM_BITS = 13;
  localparam int unsigned DIM_W        = MAX_DIM_BITS + 1;
  localparam int unsigned MAX_DIM      = 1 << MAX_DIM_BITS;
  localparam int unsigned CFG_W        = 14;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned NIB_W        = 4;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned SLOT_W       = 2;

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } npwp_reg_e;

  // live register view, dimensions already clamped
  typedef struct packed {
    logic [SLOT_W-1:0] start_slot;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } npwp_cfg_t;

  // restart request raised by any valid register write
  typedef struct packed {
    logic              restart;
    logic [SLOT_W-1:0] slot;
  } npwp_restart_t;

  typedef struct packed {
    logic              last;
    logic              row_end;
    logic [WORD_W-1:0] word;
  } npwp_res_t;

  // zero acts as one, oversized values saturate
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/npwp_cfg.sv =====
// configuration registers of the packer: start slot and clamped dimensions
// depends on npwp_pkg
`default_nettype none

module npwp_cfg import npwp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  output npwp_cfg_t             cfg_o,
  output npwp_restart_t         restart_o
);

  npwp_cfg_t cfg_q, cfg_d;
  logic      hit;

  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START: begin
          cfg_d.start_slot = cfg_wdata_i[SLOT_W-1:0];
          hit              = 1'b1;
        end
        REG_WIDTH: begin
          cfg_d.width = eff_dim(cfg_wdata_i);
          hit         = 1'b1;
        end
        REG_HEIGHT: begin
          cfg_d.height = eff_dim(cfg_wdata_i);
          hit          = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_slot <= '0;
      cfg_q.width      <= DIM_W'(1);
      cfg_q.height     <= DIM_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o             = cfg_q;
  // reload value must follow a start column written in this very cycle
  assign restart_o.restart = hit;
  assign restart_o.slot    = cfg_d.start_slot;

endmodule

`default_nettype wire

// ===== sv/npwp_core.sv =====
// packing state: accumulator, slot, column and row counts; one pixel a cycle while accept_i is high
// depends on npwp_pkg and the register view from npwp_cfg
`default_nettype none

module npwp_core import npwp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  npwp_cfg_t             cfg_i,
  input  npwp_restart_t         restart_i,
  input  wire logic             accept_i,
  input  wire logic [PIX_W-1:0] pixel_i,
  output logic                  res_valid_o,
  output npwp_res_t             res_o
);

  logic [WORD_W-1:0]       acc_q, acc_d, acc_new;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [MAX_DIM_BITS-1:0] col_q, col_d;
  logic [MAX_DIM_BITS-1:0] row_q, row_d;
  logic [DIM_W-1:0]        col_next, row_next;
  logic                    row_done, emit, last;

  always_comb begin
    acc_new  = acc_q | (WORD_W'(pixel_i[NIB_W-1:0]) << {slot_q, 2'b00});
    col_next = DIM_W'(col_q) + DIM_W'(1);
    row_next = DIM_W'(row_q) + DIM_W'(1);
    row_done = col_next >= cfg_i.width;
    emit     = (slot_q == '1) || row_done;
    last     = row_done && (row_next >= cfg_i.height);

    acc_d  = acc_q;
    slot_d = slot_q;
    col_d  = col_q;
    row_d  = row_q;
    if (restart_i.restart) begin
      acc_d  = '0;
      slot_d = restart_i.slot;
      col_d  = '0;
      row_d  = '0;
    end else if (accept_i) begin
      if (!emit) begin
        acc_d  = acc_new;
        slot_d = slot_q + SLOT_W'(1);
        col_d  = col_next[MAX_DIM_BITS-1:0];
      end else begin
        acc_d = '0;
        if (row_done) begin
          col_d  = '0;
          slot_d = cfg_i.start_slot;
          row_d  = last ? '0 : row_next[MAX_DIM_BITS-1:0];
        end else begin
          slot_d = '0;
          col_d  = col_next[MAX_DIM_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      slot_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      acc_q  <= acc_d;
      slot_q <= slot_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  assign res_valid_o   = accept_i && emit && !restart_i.restart;
  assign res_o.word    = acc_new;
  assign res_o.row_end = row_done;
  assign res_o.last    = last;

endmodule

`default_nettype wire

// ===== sv/npwp_skid.sv =====
// result register plus a skid stage holding one result while output stalls
// depends on npwp_pkg
`default_nettype none

module npwp_skid import npwp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  npwp_res_t  in_data_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output npwp_res_t  out_data_o,
  input  wire logic  out_ready_i
);

  logic      out_valid_q, skid_valid_q;
  npwp_res_t out_q, skid_q;
  logic      drain;

  assign in_ready_o = !skid_valid_q;
  assign drain      = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (drain) begin
      out_valid_q  <= skid_valid_q || in_valid_i;
      skid_valid_q <= 1'b0;
    end else if (in_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_valid_i) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/nibble_pixel_word_packer.sv =====
// 4-bit pixel word packer, top level
// each word is registered in the result register, or in the skid stage if stalled
// throughput: one pixel per clock while the skid stage is empty
// the skid stage behind the result register takes one result while output stalls
// reset clears control state; registers reset to start column 0, width 1, height 1
`default_nettype none

module nibble_pixel_word_packer import npwp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [7:0]       s_axis_tdata_i,   // [7:0] pixel
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [15:0]           m_axis_tdata_o,   // [15:0] packed_word
  output logic                  m_axis_tuser_o,   // [0] row_end
  output logic                  m_axis_tlast_o    // last word of rectangle
);

  npwp_cfg_t     cfg;
  npwp_restart_t restart;
  npwp_res_t     res, out_data;
  logic          res_valid, accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  npwp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .restart_o   (restart)
  );

  npwp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .restart_i   (restart),
    .accept_i    (accept),
    .pixel_i     (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  npwp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (out_data),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = out_data.word;
  assign m_axis_tuser_o = out_data.row_end;
  assign m_axis_tlast_o = out_data.last;

endmodule

`default_nettype wire

// ===== sv/npwp_checker.sv =====
// port-level checks of the packer, attached to the top level by bind
// depends on nibble_pixel_word_packer ports only
`default_nettype none

module npwp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // a stalled result holds its word and marks
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("output request changed while stalled");

  // the final word of a rectangle always closes a row
  a_last_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("last word without row end");

  // empty output stage means the skid stage is empty too
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with no result pending");

  // nothing is offered once reset has been seen
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output request during reset");

  // input is refused only while a result waits at the output
  a_skid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input held off with empty output");

endmodule

bind nibble_pixel_word_packer npwp_checker u_npwp_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for nibble_pixel_word_packer: random pixel streams over many
// rectangle geometries, checked word by word against a packing predictor
// depends on npwp_pkg and the nibble_pixel_word_packer top level
module tb;
  import npwp_pkg::*;

  // register index that the block must ignore
  localparam logic [1:0] REG_NONE = 2'd3;

  // tracks the packing state and holds the words the block still owes
  class packed_word_tracker;
    logic [12:0] start_col;
    logic [13:0] width_reg;
    logic [13:0] height_reg;
    logic [15:0] acc;
    logic [1:0]  slot;
    int          col;
    int          row;
    npwp_res_t   expected_words[$];
    int          errors;
    int          words_checked;
    int          rects_done;

    function new();
      start_col  = '0;
      width_reg  = 14'd1;
      height_reg = 14'd1;
      errors        = 0;
      words_checked = 0;
      rects_done    = 0;
      restart();
    endfunction

    function void restart();
      acc  = '0;
      slot = start_col[1:0];
      col  = 0;
      row  = 0;
    endfunction

    // zero acts as one, anything past the maximum saturates
    function int dim(logic [13:0] v);
      if (v == '0) begin
        return 1;
      end
      if (int'(v) > MAX_DIM) begin
        return MAX_DIM;
      end
      return int'(v);
    endfunction

    function void apply_write(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_START:  start_col  = val[12:0];
        REG_WIDTH:  width_reg  = val;
        REG_HEIGHT: height_reg = val;
        default: return;
      endcase
      restart();
    endfunction

    function void pack_pixel(logic [7:0] px);
      int        w;
      int        h;
      logic      row_done;
      npwp_res_t res;
      w = dim(width_reg);
      h = dim(height_reg);
      acc = acc | (16'(px[3:0]) << (4 * slot));
      col++;
      row_done = (col >= w);
      if (slot != 2'd3 && !row_done) begin
        slot = slot + 2'd1;
        return;
      end
      res.word    = acc;
      res.row_end = row_done;
      res.last    = row_done && (row + 1 >= h);
      expected_words.push_back(res);
      acc = '0;
      if (row_done) begin
        col  = 0;
        slot = start_col[1:0];
        row  = res.last ? 0 : row + 1;
      end else begin
        slot = 2'd0;
      end
    endfunction

    function void check_word(logic [15:0] word, logic row_end, logic last);
      npwp_res_t exp_w;
      if (expected_words.size() == 0) begin
        $error("unexpected word: packed_word %h row_end %0d last %0d", word, row_end, last);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      words_checked++;
      if (exp_w.last) begin
        rects_done++;
      end
      if (word !== exp_w.word) begin
        $error("packed_word: expected %h, got %h", exp_w.word, word);
        errors++;
      end
      if (row_end !== exp_w.row_end) begin
        $error("row_end: expected %0d, got %0d", exp_w.row_end, row_end);
        errors++;
      end
      if (last !== exp_w.last) begin
        $error("last: expected %0d, got %0d", exp_w.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void flush_missing();
      foreach (expected_words[i]) begin
        $error("missing word: expected packed_word %h row_end %0d last %0d",
               expected_words[i].word, expected_words[i].row_end, expected_words[i].last);
        errors++;
      end
      expected_words.delete();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             s_tvalid = 1'b0;
  logic [7:0]       s_tdata = '0;
  logic             m_tready = 1'b0;
  wire              s_tready;
  wire              m_tvalid;
  wire  [15:0]      m_tdata;
  wire              m_tuser;
  wire              m_tlast;

  packed_word_tracker tracker = new();

  bit tx_gaps_on  = 1'b1;
  bit rx_gaps_on  = 1'b1;
  int rx_hold_len = 0;
  int pixels_sent = 0;
  int cfg_writes  = 0;

  nibble_pixel_word_packer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_pixel(input logic [7:0] px);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    tracker.pack_pixel(px);
    pixels_sent++;
  endtask

  // stop sending and wait for every owed word, then let the last pixel settle
  task automatic settle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (tracker.pending() != 0) begin
      tracker.flush_missing();
    end
    repeat (4) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes, end_cfg drops it
  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.apply_write(idx, val);
    cfg_writes++;
  endtask

  task automatic end_cfg();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stalls, occasionally one long hold-off
  initial begin
    int stall;
    forever begin
      if (rx_hold_len > 0) begin
        stall = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        stall = rx_gaps_on ? $urandom_range(0, 8) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tracker.check_word(m_tdata, m_tuser, m_tlast);
    end
  end

  initial begin
    #(20 * 600000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int          kind;
    int          reps;
    int          count;
    int          phase_no;
    int          target;
    logic [13:0] w_val;
    logic [13:0] h_val;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset geometry is one pixel per rectangle
    send_pixel(8'hA5);
    settle();

    cfg_write(REG_START, 14'd0);
    cfg_write(REG_WIDTH, 14'd4);
    cfg_write(REG_HEIGHT, 14'd1);
    end_cfg();
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h0F);
    send_pixel(8'hF0);
    settle();

    // start in slot 3: first word closes after one pixel
    cfg_write(REG_START, 14'd8191);
    cfg_write(REG_WIDTH, 14'd3);
    cfg_write(REG_HEIGHT, 14'd2);
    end_cfg();
    repeat (6) send_pixel(8'($urandom_range(0, 255)));
    settle();

    // zero width and height act as one
    cfg_write(REG_START, 14'd2);
    cfg_write(REG_WIDTH, 14'd0);
    cfg_write(REG_HEIGHT, 14'd0);
    end_cfg();
    send_pixel(8'h7E);
    send_pixel(8'h81);
    settle();

    // oversized dims saturate, start bit 13 is dropped
    cfg_write(REG_START, 14'h3FFD);
    cfg_write(REG_WIDTH, 14'h3FFF);
    cfg_write(REG_HEIGHT, 14'h3FFF);
    end_cfg();
    send_pixel(8'h5A);
    send_pixel(8'h3C);
    send_pixel(8'hC3);
    settle();

    // unknown index in mid-rectangle must not restart
    cfg_write(REG_START, 14'd1);
    cfg_write(REG_WIDTH, 14'd8192);
    cfg_write(REG_HEIGHT, 14'd8192);
    end_cfg();
    send_pixel(8'h12);
    send_pixel(8'h34);
    settle();
    cfg_write(REG_NONE, 14'h2AAA);
    end_cfg();
    send_pixel(8'h56);
    send_pixel(8'h78);
    send_pixel(8'h9A);
    settle();

    // real write in mid-rectangle restarts it
    cfg_write(REG_WIDTH, 14'd5);
    cfg_write(REG_HEIGHT, 14'd1);
    end_cfg();
    repeat (5) send_pixel(8'($urandom_range(0, 255)));
    settle();

    target   = pixels_sent + 1600;
    phase_no = 0;
    while (pixels_sent < target) begin
      phase_no++;
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (phase_no % 12 == 5) begin
        // output held off long enough that the input side backs up
        cfg_write(REG_START, 14'($urandom_range(0, 16383)));
        cfg_write(REG_WIDTH, 14'd8);
        cfg_write(REG_HEIGHT, 14'd4);
        end_cfg();
        tx_gaps_on  = 1'b0;
        rx_hold_len = $urandom_range(100, 300);
        count = 48;
      end else if (kind < 80) begin
        w_val = 14'($urandom_range(1, 12));
        h_val = 14'($urandom_range(1, 4));
        if ($urandom_range(0, 1) == 1) begin
          cfg_write(REG_START, 14'($urandom_range(0, 16383)));
        end
        cfg_write(REG_WIDTH, w_val);
        cfg_write(REG_HEIGHT, h_val);
        end_cfg();
        if (kind < 70) begin
          reps  = $urandom_range(1, 2);
          count = int'(w_val) * int'(h_val) * reps;
        end else begin
          // possibly broken rectangle, the next valid write restarts it
          count = $urandom_range(1, int'(w_val) * int'(h_val));
        end
      end else if (kind < 85) begin
        cfg_write(REG_START, 14'($urandom_range(0, 16383)));
        cfg_write(REG_WIDTH, 14'($urandom_range(0, 1) * $urandom_range(1, 6)));
        cfg_write(REG_HEIGHT, 14'($urandom_range(0, 1) * $urandom_range(1, 3)));
        end_cfg();
        count = $urandom_range(2, 12);
      end else if (kind < 92) begin
        cfg_write(REG_START, 14'($urandom_range(0, 16383)));
        cfg_write(REG_WIDTH, 14'($urandom_range(8190, 16383)));
        cfg_write(REG_HEIGHT, 14'($urandom_range(8190, 16383)));
        end_cfg();
        count = $urandom_range(20, 60);
      end else begin
        // carry on with the current rectangle across an ignored write
        cfg_write(REG_NONE, 14'($urandom_range(0, 16383)));
        end_cfg();
        count = $urandom_range(1, 20);
      end
      repeat (count) send_pixel(8'($urandom_range(0, 255)));
      settle();
    end

    repeat (10) @(posedge clk);
    tracker.flush_missing();
    $display("sent %0d pixels over %0d phases with %0d register writes",
             pixels_sent, phase_no, cfg_writes);
    $display("checked %0d packed words, %0d complete rectangles",
             tracker.words_checked, tracker.rects_done);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
